// ===== hw/rtl/tlpl_pkg.sv =====
// tlpl_pkg: shared constants and types for the tree leaves-per-level unit
// no dependencies; used by tlpl_tables and tree_leaves_per_level_unit
package tlpl_pkg;

  localparam int unsigned IDW   = 7;   // node id and depth word width
  localparam int unsigned LVLW  = 6;   // level index width
  localparam int unsigned CNTW  = 7;   // leaf count width

  localparam logic [IDW-1:0] DEPTH_NONE = 7'd127;

  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  typedef struct packed {
    logic parent;
    logic has_child;
    logic depth;
  } tlpl_we_t;

endpackage

// ===== hw/rtl/tlpl_tables.sv =====
// tlpl_tables: parent, has-child and depth memories of the tree unit
// synchronous write, registered read; depth memory has two read ports
// depends on tlpl_pkg
module tlpl_tables #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned AW        = 6
) (
  input  logic                  clk,
  input  tlpl_pkg::tlpl_we_t    we,
  input  logic [AW-1:0]         parent_waddr,
  input  logic [tlpl_pkg::IDW-1:0] parent_wdata,
  input  logic [AW-1:0]         hc_waddr,
  input  logic                  hc_wdata,
  input  logic [AW-1:0]         depth_waddr,
  input  logic [tlpl_pkg::IDW-1:0] depth_wdata,
  input  logic [AW-1:0]         node_raddr,
  input  logic [AW-1:0]         dself_raddr,
  input  logic [AW-1:0]         dpar_raddr,
  output logic [tlpl_pkg::IDW-1:0] parent_rdata,
  output logic                  hc_rdata,
  output logic [tlpl_pkg::IDW-1:0] dself_rdata,
  output logic [tlpl_pkg::IDW-1:0] dpar_rdata
);
  import tlpl_pkg::*;

  logic [IDW-1:0] parent_mem [MAX_NODES];
  logic           hc_mem     [MAX_NODES];
  logic [IDW-1:0] depth_mem  [MAX_NODES];

  always_ff @(posedge clk) begin
    if (we.parent) begin
      parent_mem[parent_waddr] <= parent_wdata;
    end
    parent_rdata <= parent_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.has_child) begin
      hc_mem[hc_waddr] <= hc_wdata;
    end
    hc_rdata <= hc_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.depth) begin
      depth_mem[depth_waddr] <= depth_wdata;
    end
    dself_rdata <= depth_mem[dself_raddr];
    dpar_rdata  <= depth_mem[dpar_raddr];
  end

endmodule

// ===== hw/rtl/tree_leaves_per_level_unit.sv =====
// tree_leaves_per_level_unit: childless-node count per level of a rooted tree
// depends on tlpl_pkg and tlpl_tables
//
// Usage: edge beats on the in_ channel (in_req_type = 0) load one parent/child
// pair each; ids outside 1..node_count are dropped. A run beat (in_req_type = 1)
// sweeps the tree from root node 1 and returns one out_ beat per level with the
// count of childless nodes on it; out_last_level marks the final beat of a run.
// cfg_node_count sets the node count; the user must see that it is written only
// while the unit is idle, as the unit itself does not enforce this. A run makes
// one pass over the node tables per level through the read pipeline (address
// issue, stage 1, stage 2), then hands the level to the output register. After
// the last level, and after reset, a clearing pass writes every table entry,
// during which in_ready is low. The output register lets the next level's pass
// run while a result waits; if the receiver stalls, the sweep holds at the end
// of the next level.
module tree_leaves_per_level_unit #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [0:0] in_req_type,
  input  logic [6:0] in_parent_node,
  input  logic [6:0] in_child_node,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_level_index,
  output logic [6:0] out_leaf_count,
  output logic [0:0] out_last_level,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_node_count
);
  import tlpl_pkg::*;

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [AW-1:0]   LAST_ADDR = AW'(MAX_NODES - 1);
  localparam logic [IDW-1:0]  MAX_ID    = IDW'(MAX_NODES);
  localparam logic [LVLW-1:0] LAST_LVL  = LVLW'(MAX_NODES - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_PUB} state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [IDW-1:0]  cnt_r, cnt_nxt;
  logic [LVLW-1:0] level_r, level_nxt;
  logic [CNTW-1:0] leaves_r, leaves_nxt;
  logic            more_r, more_nxt;
  logic            v1_r, v1_nxt;
  logic            v2_r, v2_nxt;
  logic [AW-1:0]   i1_r, i1_nxt;
  logic [AW-1:0]   i2_r, i2_nxt;
  logic            pv2_r, pv2_nxt;
  logic            hc2_r, hc2_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [LVLW-1:0] out_level_r, out_level_nxt;
  logic [CNTW-1:0] out_leaves_r, out_leaves_nxt;
  logic            out_last_r, out_last_nxt;
  logic [IDW-1:0]  nc_r;

  logic [IDW-1:0]  n_used;
  logic            edge_ok;
  logic            pv1;
  logic [AW-1:0]   par_idx;
  logic            is_leaf;
  logic            is_asg;
  logic            fin_more;
  logic [IDW-1:0]  cur_lvl;

  tlpl_we_t        we;
  logic [AW-1:0]   parent_waddr, hc_waddr, depth_waddr;
  logic [IDW-1:0]  parent_wdata, depth_wdata;
  logic            hc_wdata;
  logic [AW-1:0]   node_raddr;
  logic [IDW-1:0]  parent_rdata, dself_rdata, dpar_rdata;
  logic            hc_rdata;

  tlpl_tables #(
    .MAX_NODES(MAX_NODES),
    .AW       (AW)
  ) u_tables (
    .clk         (clk),
    .we          (we),
    .parent_waddr(parent_waddr),
    .parent_wdata(parent_wdata),
    .hc_waddr    (hc_waddr),
    .hc_wdata    (hc_wdata),
    .depth_waddr (depth_waddr),
    .depth_wdata (depth_wdata),
    .node_raddr  (node_raddr),
    .dself_raddr (i1_r),
    .dpar_raddr  (par_idx),
    .parent_rdata(parent_rdata),
    .hc_rdata    (hc_rdata),
    .dself_rdata (dself_rdata),
    .dpar_rdata  (dpar_rdata)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_level_index = out_level_r;
  assign out_leaf_count  = out_leaves_r;
  assign out_last_level  = out_last_r;

  // clamp node count into 1..MAX_NODES
  always_comb begin
    if (nc_r == '0) begin
      n_used = IDW'(1);
    end else if (nc_r > MAX_ID) begin
      n_used = MAX_ID;
    end else begin
      n_used = nc_r;
    end
  end

  assign edge_ok = (in_parent_node != '0) && (in_parent_node <= n_used) &&
                   (in_child_node != '0) && (in_child_node <= n_used);

  // stage 1: parent word is back, look up the parent's depth
  assign pv1     = (parent_rdata != '0) && (parent_rdata <= n_used);
  assign par_idx = pv1 ? AW'(parent_rdata - IDW'(1)) : '0;

  // stage 2: both depths are back
  assign cur_lvl  = {1'b0, level_r};
  assign is_leaf  = v2_r && (dself_rdata == cur_lvl) && !hc2_r;
  assign is_asg   = v2_r && (dself_rdata == DEPTH_NONE) && pv2_r && (dpar_rdata == cur_lvl);
  assign fin_more = more_r && (level_r != LAST_LVL);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cnt_nxt        = cnt_r;
    level_nxt      = level_r;
    leaves_nxt     = leaves_r;
    more_nxt       = more_r;
    v1_nxt         = 1'b0;
    v2_nxt         = v1_r;
    i1_nxt         = i1_r;
    i2_nxt         = i1_r;
    pv2_nxt        = pv1;
    hc2_nxt        = hc_rdata;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_level_nxt  = out_level_r;
    out_leaves_nxt = out_leaves_r;
    out_last_nxt   = out_last_r;

    we           = '0;
    parent_waddr = '0;
    parent_wdata = '0;
    hc_waddr     = '0;
    hc_wdata     = 1'b0;
    depth_waddr  = '0;
    depth_wdata  = '0;
    node_raddr   = '0;

    case (state_r)
      S_CLEAR: begin
        we           = '{parent: 1'b1, has_child: 1'b1, depth: 1'b1};
        parent_waddr = clr_r;
        hc_waddr     = clr_r;
        depth_waddr  = clr_r;
        depth_wdata  = DEPTH_NONE;
        clr_nxt      = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_RUN) begin
            we.depth    = 1'b1;
            depth_waddr = '0;
            depth_wdata = '0;
            level_nxt   = '0;
            cnt_nxt     = '0;
            leaves_nxt  = '0;
            more_nxt    = 1'b0;
            state_nxt   = S_SCAN;
          end else if (edge_ok) begin
            we.parent    = 1'b1;
            parent_waddr = AW'(in_child_node - IDW'(1));
            parent_wdata = in_parent_node;
            we.has_child = 1'b1;
            hc_waddr     = AW'(in_parent_node - IDW'(1));
            hc_wdata     = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r < n_used) begin
          node_raddr = cnt_r[AW-1:0];
          v1_nxt     = 1'b1;
          i1_nxt     = cnt_r[AW-1:0];
          cnt_nxt    = cnt_r + IDW'(1);
        end
        if (is_leaf) begin
          leaves_nxt = leaves_r + CNTW'(1);
        end
        if (is_asg) begin
          we.depth    = 1'b1;
          depth_waddr = i2_r;
          depth_wdata = cur_lvl + IDW'(1);
          more_nxt    = 1'b1;
        end
        if ((cnt_r == n_used) && !v1_r && !v2_r) begin
          state_nxt = S_PUB;
        end
      end
      S_PUB: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_level_nxt  = level_r;
          out_leaves_nxt = leaves_r;
          out_last_nxt   = !fin_more;
          if (fin_more) begin
            level_nxt  = level_r + LVLW'(1);
            cnt_nxt    = '0;
            leaves_nxt = '0;
            more_nxt   = 1'b0;
            state_nxt  = S_SCAN;
          end else begin
            clr_nxt   = '0;
            state_nxt = S_CLEAR;
          end
        end
      end
      default: begin
        clr_nxt   = '0;
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      nc_r        <= IDW'(1);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        nc_r <= cfg_node_count;
      end
    end
    cnt_r        <= cnt_nxt;
    level_r      <= level_nxt;
    leaves_r     <= leaves_nxt;
    more_r       <= more_nxt;
    i1_r         <= i1_nxt;
    i2_r         <= i2_nxt;
    pv2_r        <= pv2_nxt;
    hc2_r        <= hc2_nxt;
    out_level_r  <= out_level_nxt;
    out_leaves_r <= out_leaves_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

// ===== verif/tree_leaves_per_level_unit_tb.sv =====
`timescale 1ns / 100ps
// testbench for tree_leaves_per_level_unit: loads trees, runs level counts, checks each level
// depends on tlpl_pkg and the unit's rtl; predicts results with its own copy of the node tables
module tree_leaves_per_level_unit_tb;
  import tlpl_pkg::*;

  localparam int NODES_MAX     = 64;
  localparam int SETTLE_CYCLES = 80;
  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_ITEMS  = 120;

  typedef struct {
    logic [LVLW-1:0] level;
    logic [CNTW-1:0] leaves;
    logic            last;
  } level_result_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  logic [0:0]     in_req_type;
  logic [IDW-1:0] in_parent_node;
  logic [IDW-1:0] in_child_node;
  logic           out_valid;
  logic           out_ready;
  logic [5:0]     out_level_index;
  logic [6:0]     out_leaf_count;
  logic [0:0]     out_last_level;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [6:0]     cfg_node_count;

  // predictor state
  logic [IDW-1:0] parent_of [NODES_MAX];
  logic           has_child [NODES_MAX];
  logic [IDW-1:0] depth_of  [NODES_MAX];
  logic [6:0]     node_count_reg;
  level_result_t  level_q [$];

  int errors;
  int burst_left;
  int stall_left;
  int stall_mode;

  tree_leaves_per_level_unit #(
    .MAX_NODES(NODES_MAX)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_parent_node (in_parent_node),
    .in_child_node  (in_child_node),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_level_index(out_level_index),
    .out_leaf_count (out_leaf_count),
    .out_last_level (out_last_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void clear_tables();
    for (int i = 0; i < NODES_MAX; i++) begin
      parent_of[i] = '0;
      has_child[i] = 1'b0;
      depth_of[i]  = DEPTH_NONE;
    end
  endfunction

  function automatic int nodes_in_use();
    if (node_count_reg == 0) return 1;
    if (node_count_reg > NODES_MAX) return NODES_MAX;
    return node_count_reg;
  endfunction

  function automatic void load_edge(input logic [IDW-1:0] par, input logic [IDW-1:0] chi);
    int n;
    n = nodes_in_use();
    if (par >= 1 && par <= n && chi >= 1 && chi <= n) begin
      parent_of[chi-1] = par;
      has_child[par-1] = 1'b1;
    end
  endfunction

  // level sweep from the root, one expected beat per level
  function automatic void count_leaves_per_level();
    int n;
    int lvl;
    int leaves;
    int beats;
    int par;
    bit more;
    level_result_t res;
    n = nodes_in_use();
    depth_of[0] = '0;
    lvl = 0;
    beats = 0;
    do begin
      leaves = 0;
      more = 1'b0;
      for (int i = 0; i < n; i++)
        if (depth_of[i] == lvl && !has_child[i]) leaves++;
      for (int i = 0; i < n; i++) begin
        par = parent_of[i];
        if (depth_of[i] == DEPTH_NONE && par >= 1 && par <= n && depth_of[par-1] == lvl) begin
          depth_of[i] = IDW'(lvl + 1);
          more = 1'b1;
        end
      end
      if (beats >= NODES_MAX - 1) more = 1'b0;
      res.level  = lvl[LVLW-1:0];
      res.leaves = leaves[CNTW-1:0];
      res.last   = !more;
      level_q.push_back(res);
      beats++;
      lvl++;
    end while (more);
    clear_tables();
  endfunction

  task automatic send_item(input logic req, input logic [IDW-1:0] par,
                           input logic [IDW-1:0] chi);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_parent_node <= par;
    in_child_node  <= chi;
    do @(posedge clk); while (!in_ready);
    if (req == REQ_RUN) count_leaves_per_level();
    else load_edge(par, chi);
  endtask

  task automatic set_node_count(input logic [6:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_node_count <= value;
    do @(posedge clk); while (!cfg_ready);
    node_count_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_item(REQ_RUN, 7'd0, 7'd0);
  endtask

  task automatic test_single_node_self_loop();
    set_node_count(7'd0);
    send_item(REQ_EDGE, 7'd1, 7'd1);
    send_item(REQ_EDGE, 7'd1, 7'd2);
    send_item(REQ_RUN, 7'd0, 7'd0);
  endtask

  task automatic test_bad_ids_and_cycles();
    set_node_count(7'd127);
    send_item(REQ_EDGE, 7'd1, 7'd64);
    send_item(REQ_EDGE, 7'd64, 7'd2);
    send_item(REQ_EDGE, 7'd0, 7'd5);
    send_item(REQ_EDGE, 7'd5, 7'd0);
    send_item(REQ_EDGE, 7'd65, 7'd3);
    send_item(REQ_EDGE, 7'd3, 7'd127);
    send_item(REQ_EDGE, 7'd1, 7'd3);
    send_item(REQ_EDGE, 7'd2, 7'd3);
    send_item(REQ_EDGE, 7'd10, 7'd11);
    send_item(REQ_EDGE, 7'd11, 7'd10);
    send_item(REQ_RUN, 7'd127, 7'd127);
  endtask

  task automatic test_small_tree();
    set_node_count(7'd5);
    send_item(REQ_EDGE, 7'd1, 7'd2);
    send_item(REQ_EDGE, 7'd1, 7'd3);
    send_item(REQ_EDGE, 7'd2, 7'd4);
    send_item(REQ_EDGE, 7'd6, 7'd5);
    send_item(REQ_RUN, 7'd64, 7'd64);
  endtask

  task automatic test_random_trees(input int item_goal);
    int sent;
    int tree_no;
    int n;
    int shape;
    int cnt;
    int j;
    logic [IDW-1:0] par_list [NODES_MAX + 4];
    logic [IDW-1:0] chi_list [NODES_MAX + 4];
    logic [IDW-1:0] tmp;
    sent = 0;
    tree_no = 0;
    while (sent < item_goal) begin
      if (tree_no == 2) begin
        n = NODES_MAX;
        shape = 0;
      end else begin
        n = $urandom_range(2, 10);
        shape = $urandom_range(0, 2);
      end
      set_node_count(7'(n));
      cnt = 0;
      for (int k = 2; k <= n; k++) begin
        if (tree_no != 2 && $urandom_range(0, 15) == 0) continue;
        chi_list[cnt] = IDW'(k);
        case (shape)
          0: par_list[cnt] = IDW'(k - 1);
          1: par_list[cnt] = IDW'($urandom_range(1, k - 1));
          default: par_list[cnt] = IDW'($urandom_range(1, (k > 2) ? 2 : 1));
        endcase
        cnt++;
      end
      if (tree_no != 2) begin
        for (int k = $urandom_range(0, 2); k > 0; k--) begin
          par_list[cnt] = $urandom_range(0, 1) ? IDW'($urandom_range(0, 127)) :
                                                 IDW'($urandom_range(1, n));
          chi_list[cnt] = $urandom_range(0, 1) ? IDW'($urandom_range(0, 127)) :
                                                 IDW'($urandom_range(1, n));
          cnt++;
        end
      end
      for (int k = cnt - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = par_list[k]; par_list[k] = par_list[j]; par_list[j] = tmp;
        tmp = chi_list[k]; chi_list[k] = chi_list[j]; chi_list[j] = tmp;
      end
      for (int k = 0; k < cnt; k++) send_item(REQ_EDGE, par_list[k], chi_list[k]);
      send_item(REQ_RUN, IDW'($urandom_range(0, 127)), IDW'($urandom_range(0, 127)));
      sent += cnt + 1;
      tree_no++;
    end
  endtask

  // receiver stall patterns
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_left % 4 != 0);
      default: out_ready <= (stall_left < 3);
    endcase
  end

  always @(posedge clk) begin : check_levels
    level_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (level_q.size() == 0) begin
        if (errors < 10)
          $display("ERROR: unexpected beat level %0d leaves %0d last %0b",
                   out_level_index, out_leaf_count, out_last_level);
        errors++;
      end else begin
        want = level_q.pop_front();
        if (out_level_index !== want.level || out_leaf_count !== want.leaves ||
            out_last_level !== want.last) begin
          if (errors < 10)
            $display("ERROR: level exp %0d/%0d/%0b got %0d/%0d/%0b", want.level,
                     want.leaves, want.last, out_level_index, out_leaf_count,
                     out_last_level);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_EDGE;
    in_parent_node = '0;
    in_child_node  = '0;
    cfg_valid      = 1'b0;
    cfg_node_count = 7'd1;
    burst_left     = 0;
    node_count_reg = 7'd1;
    clear_tables();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_single_node_self_loop();
    test_bad_ids_and_cycles();
    test_small_tree();
    test_random_trees(RANDOM_ITEMS);

    @(negedge clk);
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && level_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
